/* hw/rtl/sstm_pkg.sv */
package sstm_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [15:0] AllId = 16'hFFFF;
  localparam logic [7:0] AnySel = 8'hFF;
  localparam logic [15:0] MinPerHour = 16'd60;

  typedef enum logic [2:0] {
    KindAdd = 3'd0,
    KindEnable = 3'd1,
    KindDelete = 3'd2,
    KindMinute = 3'd3,
    KindPowerOn = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    StAdded = 4'd0,
    StEdited = 4'd1,
    StFull = 4'd2,
    StEnabled = 4'd3,
    StSwitched = 4'd4,
    StNotFound = 4'd5,
    StDeleted = 4'd6,
    StAllDeleted = 4'd7,
    StFired = 4'd8,
    StNoneFired = 4'd9,
    StInvalidId = 4'd10
  } status_e;

  typedef enum logic [2:0] {
    ExIdle,
    ExScan,
    ExMove,
    ExDone
  } exec_state_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [15:0] target_id;
    logic enable_flag;
    logic [31:0] start_day;
    logic [31:0] stop_day;
    logic [7:0] month_sel;
    logic [7:0] day_sel;
    logic [7:0] weekday_mask;
    logic [7:0] hour_sel;
    logic [7:0] minute_sel;
    logic [7:0] relay_level;
    logic [7:0] dim_percent;
  } req_t;

  typedef struct packed {
    logic [3:0] status;
    logic [15:0] active_id;
    logic [7:0] active_dim;
    logic [7:0] active_relay;
    logic [5:0] scene_count;
  } rsp_t;

  // one stored scene
  typedef struct packed {
    logic [15:0] id;
    logic en;
    logic [31:0] start_day;
    logic [31:0] stop_day;
    logic [7:0] month;
    logic [7:0] mday;
    logic [7:0] wmask;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] relay;
    logic [7:0] dim;
  } entry_t;

  // classified request handed from front to back
  typedef struct packed {
    req_t req;
    logic bad_id;
    logic all_id;
    logic [2:0] wpos;
    logic wpos_ok;
  } job_t;

endpackage

/* hw/rtl/sstm_front.sv */
module sstm_front (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  output logic req_stall_o,
  input sstm_pkg::req_t req_i,
  output logic job_valid_o,
  input logic job_stall_i,
  output sstm_pkg::job_t job_o
);

  // two-entry queue
  sstm_pkg::job_t q_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  sstm_pkg::job_t job_d;
  logic push, pop;

  always_comb begin
    job_d.req = req_i;
    job_d.bad_id = (req_i.kind <= sstm_pkg::KindDelete) && (req_i.target_id == 16'd0);
    job_d.all_id = req_i.target_id == sstm_pkg::AllId;
    job_d.wpos = (req_i.weekday_mask == 8'd0) ? 3'd6 : 3'(req_i.weekday_mask - 8'd1);
    job_d.wpos_ok = (req_i.weekday_mask == 8'd0) || (req_i.weekday_mask <= 8'd8);
  end

  assign req_stall_o = cnt_q == 2'd2;
  assign push = req_valid_i && !req_stall_o;
  assign pop = job_valid_o && !job_stall_i;
  assign job_valid_o = cnt_q != 2'd0;

  always_comb begin
    job_o = q_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= job_d;
    end
  end

endmodule

/* hw/rtl/sstm_back.sv */
module sstm_back (
  input logic clk_i,
  input logic rst_ni,
  input logic job_valid_i,
  output logic job_stall_o,
  input sstm_pkg::job_t job_i,
  input logic [15:0] now_i,
  output logic rsp_valid_o,
  input logic rsp_stall_i,
  output sstm_pkg::rsp_t rsp_o
);

  sstm_pkg::entry_t mem [sstm_pkg::TableDepth];

  sstm_pkg::exec_state_e state_q, state_d;
  logic [sstm_pkg::CntW-1:0] held_q, held_d;
  logic sched_q, sched_d;
  logic [7:0] last_min_q, last_min_d;
  logic [sstm_pkg::CntW-1:0] idx_q, idx_d;
  logic found_q, found_d;
  logic [sstm_pkg::IdxW-1:0] hit_q, hit_d;
  logic [15:0] best_q, best_d;
  sstm_pkg::rsp_t res_q, res_d;
  logic rv_q, rv_d;
  sstm_pkg::entry_t rd_q;
  logic rd_en;
  logic [sstm_pkg::IdxW-1:0] rd_addr;
  logic wr_en;
  logic [sstm_pkg::IdxW-1:0] wr_addr;
  sstm_pkg::entry_t wr_data;
  logic rd_ok_q, rd_ok_d;

  sstm_pkg::req_t r;
  logic date_ok, time_ok;
  logic [15:0] t;
  logic wbit;
  sstm_pkg::entry_t new_e;

  assign r = job_i.req;
  assign rsp_valid_o = rv_q;
  assign rsp_o = res_q;

  always_comb begin
    new_e.id = r.target_id;
    new_e.en = r.enable_flag;
    new_e.start_day = r.start_day;
    new_e.stop_day = r.stop_day;
    new_e.month = r.month_sel;
    new_e.mday = r.day_sel;
    new_e.wmask = r.weekday_mask;
    new_e.hour = r.hour_sel;
    new_e.minute = r.minute_sel;
    new_e.relay = r.relay_level;
    new_e.dim = r.dim_percent;
    wbit = job_i.wpos_ok && rd_q.wmask[job_i.wpos];
    date_ok = rd_q.en && rd_q.start_day <= r.start_day && rd_q.stop_day >= r.start_day
      && (rd_q.month == sstm_pkg::AnySel || rd_q.month == r.month_sel)
      && (rd_q.mday == sstm_pkg::AnySel || rd_q.mday == r.day_sel)
      && (rd_q.wmask == sstm_pkg::AnySel || wbit);
    time_ok = (rd_q.hour == sstm_pkg::AnySel || rd_q.hour == r.hour_sel)
      && (rd_q.minute == sstm_pkg::AnySel || rd_q.minute == r.minute_sel);
    t = 16'(rd_q.hour) * sstm_pkg::MinPerHour + 16'(rd_q.minute);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sstm_pkg::ExIdle;
      held_q <= '0;
      sched_q <= 1'b0;
      last_min_q <= 8'd0;
      rv_q <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q <= held_d;
      sched_q <= sched_d;
      last_min_q <= last_min_d;
      rv_q <= rv_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    found_q <= found_d;
    hit_q <= hit_d;
    best_q <= best_d;
    res_q <= res_d;
    if (rd_en) rd_q <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_comb begin
    state_d = state_q;
    held_d = held_q;
    sched_d = sched_q;
    last_min_d = last_min_q;
    idx_d = idx_q;
    found_d = found_q;
    hit_d = hit_q;
    best_d = best_q;
    res_d = res_q;
    rv_d = rv_q && rsp_stall_i;
    rd_en = 1'b0;
    rd_addr = idx_q[sstm_pkg::IdxW-1:0];
    rd_ok_d = 1'b0;
    wr_en = 1'b0;
    wr_addr = hit_q;
    wr_data = new_e;
    job_stall_o = 1'b1;
    case (state_q)
      sstm_pkg::ExIdle: begin
        if (job_valid_i && !rv_q) begin
          idx_d = '0;
          found_d = 1'b0;
          best_d = 16'd0;
          res_d = '0;
          res_d.status = sstm_pkg::StNoneFired;
          state_d = sstm_pkg::ExScan;
          if (job_i.bad_id) begin
            res_d.status = sstm_pkg::StInvalidId;
            state_d = sstm_pkg::ExDone;
          end else if (r.kind == sstm_pkg::KindEnable && job_i.all_id) begin
            sched_d = r.enable_flag;
            res_d.status = sstm_pkg::StSwitched;
            state_d = sstm_pkg::ExDone;
          end else if (r.kind == sstm_pkg::KindDelete && job_i.all_id) begin
            held_d = '0;
            res_d.status = sstm_pkg::StAllDeleted;
            state_d = sstm_pkg::ExDone;
          end else if (r.kind == sstm_pkg::KindMinute) begin
            last_min_d = r.minute_sel;
            if (!sched_q || r.minute_sel == last_min_q) state_d = sstm_pkg::ExDone;
          end else if (r.kind == sstm_pkg::KindPowerOn) begin
            if (!sched_q) state_d = sstm_pkg::ExDone;
          end else if (r.kind > sstm_pkg::KindPowerOn) begin
            state_d = sstm_pkg::ExDone;
          end
        end
      end
      sstm_pkg::ExScan: begin
        // read issue for idx, evaluate previous read
        if (rd_ok_q) begin
          case (r.kind)
            sstm_pkg::KindMinute: begin
              if (date_ok && time_ok && !found_d) begin
                found_d = 1'b1;
                res_d.status = sstm_pkg::StFired;
                res_d.active_id = rd_q.id;
                res_d.active_dim = rd_q.dim;
                res_d.active_relay = rd_q.relay;
              end
            end
            sstm_pkg::KindPowerOn: begin
              if (date_ok && best_q <= t && t <= now_i) begin
                best_d = t;
                res_d.status = sstm_pkg::StFired;
                res_d.active_id = rd_q.id;
                res_d.active_dim = rd_q.dim;
                res_d.active_relay = rd_q.relay;
              end
            end
            default: begin
              if (rd_q.id == r.target_id && !found_d) begin
                found_d = 1'b1;
                hit_d = sstm_pkg::IdxW'(idx_q - 1'b1);
              end
            end
          endcase
        end
        if (idx_q < held_q && !found_d) begin
          rd_en = 1'b1;
          rd_ok_d = 1'b1;
          idx_d = idx_q + 1'b1;
        end else if (!rd_ok_q || found_d || idx_q >= held_q) begin
          if (!(rd_ok_q && !found_d && idx_q < held_q)) begin
            state_d = sstm_pkg::ExDone;
            case (r.kind)
              sstm_pkg::KindAdd: begin
                if (found_d) begin
                  wr_en = 1'b1;
                  wr_addr = hit_d;
                  res_d.status = sstm_pkg::StEdited;
                end else if (held_q >= sstm_pkg::CntW'(sstm_pkg::TableDepth)) begin
                  res_d.status = sstm_pkg::StFull;
                end else begin
                  wr_en = 1'b1;
                  wr_addr = held_q[sstm_pkg::IdxW-1:0];
                  held_d = held_q + 1'b1;
                  res_d.status = sstm_pkg::StAdded;
                end
              end
              sstm_pkg::KindEnable: begin
                if (found_d) begin
                  rd_en = 1'b1;
                  rd_addr = hit_d;
                  res_d.status = sstm_pkg::StEnabled;
                  state_d = sstm_pkg::ExMove;
                end else res_d.status = sstm_pkg::StNotFound;
              end
              sstm_pkg::KindDelete: begin
                if (found_d) begin
                  rd_en = 1'b1;
                  rd_addr = sstm_pkg::IdxW'(held_q - 1'b1);
                  held_d = held_q - 1'b1;
                  res_d.status = sstm_pkg::StDeleted;
                  state_d = sstm_pkg::ExMove;
                end else res_d.status = sstm_pkg::StNotFound;
              end
              default: ;
            endcase
          end
        end
      end
      sstm_pkg::ExMove: begin
        wr_en = 1'b1;
        wr_addr = hit_q;
        wr_data = rd_q;
        if (r.kind == sstm_pkg::KindEnable) wr_data.en = r.enable_flag;
        state_d = sstm_pkg::ExDone;
      end
      sstm_pkg::ExDone: begin
        job_stall_o = 1'b0;
        res_d.scene_count = 6'(held_q);
        rv_d = 1'b1;
        state_d = sstm_pkg::ExIdle;
      end
      default: state_d = sstm_pkg::ExIdle;
    endcase
  end

endmodule

/* hw/rtl/scheduled_scene_table_matcher.sv */
// a result follows the entry scan (one table entry read per cycle) and, for enable and
// delete, a move step (ExMove) that rewrites one entry; requests are handled one at a
// time, and a new scan starts only once the previous result has been taken
// a two-deep queue parts the request side from the scan engine
// reset: asynchronous active low; table empty, schedule off, last minute zero
module scheduled_scene_table_matcher (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  output logic in_stall_o,
  input sstm_pkg::req_t in_data_i,
  output logic out_valid_o,
  input logic out_stall_i,
  output sstm_pkg::rsp_t out_data_o
);

  logic job_valid, job_stall;
  sstm_pkg::job_t job;
  logic [15:0] now;

  sstm_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(in_valid_i), .req_stall_o(in_stall_o), .req_i(in_data_i),
    .job_valid_o(job_valid), .job_stall_i(job_stall), .job_o(job)
  );

  assign now = 16'(job.req.hour_sel) * sstm_pkg::MinPerHour + 16'(job.req.minute_sel);

  sstm_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .job_valid_i(job_valid), .job_stall_o(job_stall), .job_i(job), .now_i(now),
    .rsp_valid_o(out_valid_o), .rsp_stall_i(out_stall_i), .rsp_o(out_data_o)
  );

endmodule

/* sim/scheduled_scene_table_matcher_tb.sv */
`timescale 1ns / 100ps

module scheduled_scene_table_matcher_tb;

  class scene_scoreboard;
    sstm_pkg::entry_t tbl [sstm_pkg::TableDepth];
    int unsigned held;
    bit sched_on;
    logic [7:0] prev_minute;
    sstm_pkg::rsp_t pending_rsp [$];
    int unsigned n_err;
    int unsigned n_fired;

    function new();
      held = 0;
      sched_on = 0;
      prev_minute = '0;
      n_err = 0;
      n_fired = 0;
    endfunction

    function int find_scene(logic [15:0] id);
      for (int i = 0; i < held; i++) if (tbl[i].id == id) return i;
      return -1;
    endfunction

    function bit date_ok(sstm_pkg::entry_t e, sstm_pkg::req_t r);
      int unsigned pos;
      bit b;
      pos = (r.weekday_mask == 0) ? 6 : r.weekday_mask - 1;
      b = (pos < 8) ? e.wmask[pos] : 1'b0;
      if (!(e.start_day <= r.start_day && e.stop_day >= r.start_day)) return 0;
      if (!(e.month == sstm_pkg::AnySel || e.month == r.month_sel)) return 0;
      if (!(e.mday == sstm_pkg::AnySel || e.mday == r.day_sel)) return 0;
      if (!(e.wmask == sstm_pkg::AnySel || b)) return 0;
      return 1;
    endfunction

    function sstm_pkg::entry_t to_entry(sstm_pkg::req_t r);
      sstm_pkg::entry_t e;
      e.id = r.target_id; e.en = r.enable_flag;
      e.start_day = r.start_day; e.stop_day = r.stop_day;
      e.month = r.month_sel; e.mday = r.day_sel; e.wmask = r.weekday_mask;
      e.hour = r.hour_sel; e.minute = r.minute_sel;
      e.relay = r.relay_level; e.dim = r.dim_percent;
      return e;
    endfunction

    function void note_request(sstm_pkg::req_t r);
      sstm_pkg::rsp_t p;
      int k;
      int unsigned now, best, t;
      p = '0;
      p.status = sstm_pkg::StNoneFired;
      if (r.kind <= sstm_pkg::KindDelete && r.target_id == 0) begin
        p.status = sstm_pkg::StInvalidId;
      end else begin
        case (r.kind)
          sstm_pkg::KindAdd: begin
            k = find_scene(r.target_id);
            if (k >= 0) begin
              tbl[k] = to_entry(r); p.status = sstm_pkg::StEdited;
            end else if (held >= sstm_pkg::TableDepth) begin
              p.status = sstm_pkg::StFull;
            end else begin
              tbl[held] = to_entry(r); held++; p.status = sstm_pkg::StAdded;
            end
          end
          sstm_pkg::KindEnable: begin
            if (r.target_id == sstm_pkg::AllId) begin
              sched_on = r.enable_flag; p.status = sstm_pkg::StSwitched;
            end else begin
              k = find_scene(r.target_id);
              if (k >= 0) begin
                tbl[k].en = r.enable_flag; p.status = sstm_pkg::StEnabled;
              end else p.status = sstm_pkg::StNotFound;
            end
          end
          sstm_pkg::KindDelete: begin
            if (r.target_id == sstm_pkg::AllId) begin
              held = 0; p.status = sstm_pkg::StAllDeleted;
            end else begin
              k = find_scene(r.target_id);
              if (k >= 0) begin
                held--; tbl[k] = tbl[held]; p.status = sstm_pkg::StDeleted;
              end else p.status = sstm_pkg::StNotFound;
            end
          end
          sstm_pkg::KindMinute: begin
            if (sched_on && r.minute_sel != prev_minute) begin
              for (int i = 0; i < held; i++) begin
                if (tbl[i].en && date_ok(tbl[i], r) &&
                    (tbl[i].hour == sstm_pkg::AnySel || tbl[i].hour == r.hour_sel) &&
                    (tbl[i].minute == sstm_pkg::AnySel ||
                     tbl[i].minute == r.minute_sel)) begin
                  p.status = sstm_pkg::StFired; p.active_id = tbl[i].id;
                  p.active_dim = tbl[i].dim; p.active_relay = tbl[i].relay;
                  break;
                end
              end
            end
            prev_minute = r.minute_sel;
          end
          sstm_pkg::KindPowerOn: begin
            now = r.hour_sel * 60 + r.minute_sel;
            best = 0;
            if (sched_on) begin
              for (int i = 0; i < held; i++) begin
                t = tbl[i].hour * 60 + tbl[i].minute;
                if (tbl[i].en && date_ok(tbl[i], r) && best <= t && t <= now) begin
                  p.status = sstm_pkg::StFired; p.active_id = tbl[i].id;
                  p.active_dim = tbl[i].dim; p.active_relay = tbl[i].relay;
                  best = t;
                end
              end
            end
          end
          default: ;
        endcase
      end
      p.scene_count = held[5:0];
      pending_rsp.push_back(p);
    endfunction

    function void check_result(sstm_pkg::rsp_t a);
      sstm_pkg::rsp_t e;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        n_err++;
        return;
      end
      e = pending_rsp.pop_front();
      if (e.status == sstm_pkg::StFired) n_fired++;
      if (a.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, a.status); n_err++;
      end
      if (a.active_id !== e.active_id) begin
        $display("%0t: active_id exp %h got %h", $time, e.active_id, a.active_id); n_err++;
      end
      if (a.active_dim !== e.active_dim) begin
        $display("%0t: active_dim exp %h got %h", $time, e.active_dim, a.active_dim);
        n_err++;
      end
      if (a.active_relay !== e.active_relay) begin
        $display("%0t: active_relay exp %h got %h", $time, e.active_relay, a.active_relay);
        n_err++;
      end
      if (a.scene_count !== e.scene_count) begin
        $display("%0t: scene_count exp %0d got %0d", $time, e.scene_count, a.scene_count);
        n_err++;
      end
    endfunction
  endclass

  localparam int unsigned StallLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sstm_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sstm_pkg::rsp_t out_data_o;

  scene_scoreboard sb;
  bit quiet_phase = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned n_sent = 0;
  logic [15:0] id_pool [8];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  scheduled_scene_table_matcher dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // result side: sample at rising edge, change stall at falling edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (!quiet_phase && $urandom_range(99) < 19);
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // valid stays high into the next request unless the sender idles
  task automatic send_request(sstm_pkg::req_t r);
    while (!quiet_phase && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(r);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_rsp.size() != 0) @(negedge clk_i);
  endtask

  function automatic sstm_pkg::req_t rand_request();
    sstm_pkg::req_t r;
    logic [159:0] raw;
    int unsigned sel;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(sstm_pkg::req_t)-1:0];
    sel = $urandom_range(99);
    r.kind = (sel < 30) ? sstm_pkg::KindAdd : (sel < 42) ? sstm_pkg::KindEnable :
             (sel < 52) ? sstm_pkg::KindDelete : (sel < 78) ? sstm_pkg::KindMinute :
             (sel < 97) ? sstm_pkg::KindPowerOn : 3'($urandom_range(7, 5));
    sel = $urandom_range(99);
    r.target_id = (sel < 80) ? id_pool[3'($urandom_range(7))] : (sel < 84) ? 16'h0 :
                  (sel < 88) ? sstm_pkg::AllId : 16'($urandom);
    if (r.kind == sstm_pkg::KindEnable && r.target_id == sstm_pkg::AllId)
      r.enable_flag = ($urandom_range(9) < 8);
    if (r.kind == sstm_pkg::KindDelete && r.target_id == sstm_pkg::AllId &&
        $urandom_range(3) != 0)
      r.target_id = id_pool[0];
    if (r.kind == sstm_pkg::KindAdd) begin
      // mostly broad windows and wildcards so that time checks can fire
      if ($urandom_range(3) != 0) begin
        r.start_day = $urandom_range(10); r.stop_day = 32'hFFFF_FFF0 + $urandom_range(15);
      end
      if ($urandom_range(2) != 0) r.month_sel = sstm_pkg::AnySel;
      else r.month_sel = 8'($urandom_range(11));
      if ($urandom_range(2) != 0) r.day_sel = sstm_pkg::AnySel;
      else r.day_sel = 8'($urandom_range(31));
      if ($urandom_range(2) != 0) r.weekday_mask = sstm_pkg::AnySel;
      if ($urandom_range(3) != 0) r.hour_sel = 8'($urandom_range(23));
      else if ($urandom_range(1)) r.hour_sel = sstm_pkg::AnySel;
      if ($urandom_range(3) != 0) r.minute_sel = 8'($urandom_range(59));
      else if ($urandom_range(1)) r.minute_sel = sstm_pkg::AnySel;
      if ($urandom_range(4) != 0) r.enable_flag = 1'b1;
    end else if (r.kind == sstm_pkg::KindMinute || r.kind == sstm_pkg::KindPowerOn) begin
      if ($urandom_range(4) != 0) begin
        r.start_day = $urandom_range(1000); r.month_sel = 8'($urandom_range(11));
        r.day_sel = 8'($urandom_range(31)); r.weekday_mask = 8'($urandom_range(6));
        r.hour_sel = 8'($urandom_range(23)); r.minute_sel = 8'($urandom_range(59));
      end
    end
    return r;
  endfunction

  initial begin
    sstm_pkg::req_t r;
    sb = new();
    for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom_range(1, 65534));
    id_pool[7] = 16'hFFFE;
    id_pool[6] = 16'h0001;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    r = '0; r.kind = sstm_pkg::KindAdd; r.target_id = 16'h0; send_request(r);
    r.kind = sstm_pkg::KindEnable; send_request(r);
    r.kind = sstm_pkg::KindDelete; send_request(r);
    r = '1; r.kind = sstm_pkg::KindAdd; r.target_id = 16'h0001; r.start_day = 32'd0;
    send_request(r);
    r.relay_level = 8'h00; r.dim_percent = 8'h7F; send_request(r);
    r.kind = sstm_pkg::KindMinute; r.minute_sel = 8'd5; send_request(r);
    r = '0; r.kind = sstm_pkg::KindEnable; r.target_id = sstm_pkg::AllId;
    r.enable_flag = 1'b1; send_request(r);
    r = '0; r.kind = sstm_pkg::KindMinute; r.start_day = 32'hFFFF_FFFF; r.minute_sel = 8'd7;
    r.weekday_mask = 8'd0; send_request(r);
    send_request(r);
    r.weekday_mask = 8'd200; r.minute_sel = 8'd8; send_request(r);
    r = '0; r.kind = sstm_pkg::KindPowerOn; r.hour_sel = 8'd23; r.minute_sel = 8'd59;
    r.start_day = 32'd5; send_request(r);
    r = '0; r.kind = sstm_pkg::KindAdd; r.target_id = 16'h0002; r.enable_flag = 1'b1;
    r.stop_day = 32'hFFFF_FFFF; r.month_sel = sstm_pkg::AnySel; r.day_sel = sstm_pkg::AnySel;
    r.weekday_mask = 8'h01; r.hour_sel = 8'd6; r.minute_sel = 8'd30; send_request(r);
    r.kind = sstm_pkg::KindPowerOn; r.target_id = 16'h0; r.weekday_mask = 8'd1;
    r.hour_sel = 8'd7; r.minute_sel = 8'd0; send_request(r);
    r = '0; r.kind = sstm_pkg::KindEnable; r.target_id = 16'h0002; send_request(r);
    r.target_id = 16'h1234; send_request(r);
    r.kind = 3'd5; send_request(r);
    r.kind = 3'd7; send_request(r);
    for (int i = 0; i < 33; i++) begin
      r = '0; r.kind = sstm_pkg::KindAdd; r.target_id = 16'(16'h0100 + i); send_request(r);
    end
    r.target_id = 16'h0101; r.dim_percent = 8'hFF; send_request(r);
    r = '0; r.kind = sstm_pkg::KindDelete; r.target_id = 16'h0105; send_request(r);
    r.target_id = 16'h0105; send_request(r);
    r.target_id = sstm_pkg::AllId; send_request(r);

    // pause until the block has answered everything
    stop_sending();
    wait_drained();
    repeat (40) @(negedge clk_i);

    for (int n = 0; n < 700; n++) begin
      quiet_phase = (n >= 300 && n < 400);
      if (n == 500) begin
        stop_sending();
        wait_drained();
      end
      send_request(rand_request());
    end
    stop_sending();
    quiet_phase = 1'b0;

    while (sb.pending_rsp.size() != 0) @(negedge clk_i);
    repeat (sstm_pkg::TableDepth + 10) @(negedge clk_i);
    $display("%0d requests sent, %0d scenes fired, table held %0d at the end",
             n_sent, sb.n_fired, sb.held);
    if (sb.n_err == 0 && sb.pending_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
